// File: design/pfd_pkg.sv
// Shared types, register map and microcode for the filtered-derivative PID block.
`default_nettype none
package pfd_pkg;

  // Register map (word index = paddr[4:2])
  localparam int PADDR_W = 5;
  localparam int REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_GAIN_P         = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_GAIN_I         = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_GAIN_D         = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_STEP_TIME      = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_STEP_RATE      = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_FILTER_ALPHA   = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_INTEGRAL_LIMIT = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_OUT_CLAMP      = 3'd7;

  localparam int COEF_W  = 31;
  localparam int ALPHA_W = 25;
  localparam int GAIN_FRAC = 24;
  localparam logic [ALPHA_W-1:0] ALPHA_ONE = 25'h100_0000;

  localparam logic [COEF_W-1:0]  RST_GAIN      = 31'd0;
  localparam logic [COEF_W-1:0]  RST_STEP_TIME = 31'd16777;
  localparam logic [COEF_W-1:0]  RST_STEP_RATE = 31'd65536000;
  localparam logic [ALPHA_W-1:0] RST_ALPHA     = 25'd0;
  localparam logic [COEF_W-1:0]  RST_LIMIT     = 31'h7FFF_FFFF;

  typedef struct packed {
    logic [COEF_W-1:0]  gain_p;
    logic [COEF_W-1:0]  gain_i;
    logic [COEF_W-1:0]  gain_d;
    logic [COEF_W-1:0]  step_time;
    logic [COEF_W-1:0]  step_rate;
    logic [ALPHA_W-1:0] filter_alpha;
    logic [COEF_W-1:0]  integral_limit;
    logic [COEF_W-1:0]  out_clamp;
  } cfg_t;

  // Multiplier operand pairs
  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_E_DT,
    MUL_DIFF_RINV,
    MUL_E_KP,
    MUL_DRATE_ALPHA,
    MUL_INT_KI,
    MUL_FILT_KD
  } mul_sel_t;

  // Datapath operations
  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_INT,
    OP_RATE,
    OP_ACC_LOAD,
    OP_FILT,
    OP_ACC_ADD,
    OP_ACC_SUB,
    OP_OUT
  } alu_op_t;

  // Hold conditions: step repeats (jump to itself) while the condition is true
  typedef enum logic [1:0] {
    C_NONE,
    C_WAIT_IN,
    C_WAIT_OUT
  } cond_t;

  typedef struct packed {
    mul_sel_t mul_sel;
    alu_op_t  alu_op;
    cond_t    cond;
    logic     wrap;      // last step: next pc is 0
  } ctl_word_t;

  typedef struct packed {
    mul_sel_t mul_sel;
    alu_op_t  alu_op;
    logic     go;        // step executes this cycle
  } ctl_t;

  localparam int PC_W = 4;

  // Microcode program, one PID step
  function automatic ctl_word_t rom_word(input logic [PC_W-1:0] pc);
    ctl_word_t w;
    w = '{mul_sel: MUL_NONE, alu_op: OP_NOP, cond: C_NONE, wrap: 1'b1};
    unique case (pc)
      4'd0: w = '{mul_sel: MUL_NONE,        alu_op: OP_LOAD,     cond: C_WAIT_IN,  wrap: 1'b0};
      4'd1: w = '{mul_sel: MUL_E_DT,        alu_op: OP_NOP,      cond: C_NONE,     wrap: 1'b0};
      4'd2: w = '{mul_sel: MUL_DIFF_RINV,   alu_op: OP_INT,      cond: C_NONE,     wrap: 1'b0};
      4'd3: w = '{mul_sel: MUL_E_KP,        alu_op: OP_RATE,     cond: C_NONE,     wrap: 1'b0};
      4'd4: w = '{mul_sel: MUL_DRATE_ALPHA, alu_op: OP_ACC_LOAD, cond: C_NONE,     wrap: 1'b0};
      4'd5: w = '{mul_sel: MUL_INT_KI,      alu_op: OP_FILT,     cond: C_NONE,     wrap: 1'b0};
      4'd6: w = '{mul_sel: MUL_FILT_KD,     alu_op: OP_ACC_ADD,  cond: C_NONE,     wrap: 1'b0};
      4'd7: w = '{mul_sel: MUL_NONE,        alu_op: OP_ACC_SUB,  cond: C_NONE,     wrap: 1'b0};
      4'd8: w = '{mul_sel: MUL_NONE,        alu_op: OP_OUT,      cond: C_WAIT_OUT, wrap: 1'b1};
      default: w = '{mul_sel: MUL_NONE, alu_op: OP_NOP, cond: C_NONE, wrap: 1'b1};
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

// File: design/pfd_sample_if.sv
// Input channel: setpoint and measurement word.
`default_nettype none
interface pfd_sample_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] setpoint;
  logic signed [31:0] measured;

  modport source(output valid, output setpoint, output measured, input ready);
  modport sink(input valid, input setpoint, input measured, output ready);
endinterface
`default_nettype wire

// File: design/pfd_command_if.sv
// Output channel: saturated control word and saturation flag.
`default_nettype none
interface pfd_command_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] control_output;
  logic               output_saturated;

  modport source(output valid, output control_output, output output_saturated, input ready);
  modport sink(input valid, input control_output, input output_saturated, output ready);
endinterface
`default_nettype wire

// File: design/pid_filtered_derivative_core.sv
// Top level: PID step with filtered derivative on measurement.
//
//  channel   dir  handshake       word contents
//  sample    in   valid/ready     setpoint, measured (signed Q16.16)
//  command   out  valid/ready     control_output (signed Q16.16), output_saturated
//  apb       in   psel/penable    8 config registers at 4*i, 32-bit data, pready tied high
//
//  The result is written at the last step of the 9-step microcode program,
//  which drives a single 33x32 multiplier (at most one product per step); a
//  new sample is not taken until the previous sample's program has finished.
//  A new sample is taken only at step 0; the result register lets the next
//  sample start while the previous result waits. The final step holds while
//  the result slot is still full. rst is synchronous: it clears the program
//  counter, the integral, last measurement and filtered rate, and returns the
//  config registers to their reset values.
`default_nettype none
module pid_filtered_derivative_core #(
  parameter int FRAC_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  pfd_sample_if.sink                  sample,
  pfd_command_if.source               command,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [pfd_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import pfd_pkg::*;

  cfg_t cfg;      // live configuration
  ctl_t ctl;      // decoded microcode step
  logic out_busy; // result register full and not draining

  assign pready = 1'b1;

  pfd_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  // sequencer: step 0 waits for a sample, step 8 waits for a free result slot
  pfd_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (sample.valid),
    .in_ready (sample.ready),
    .out_busy (out_busy),
    .ctl      (ctl)
  );

  // datapath: error/diff latch, shared multiplier, integral clamp,
  // derivative saturation, low-pass, gain sum and output clamp
  pfd_datapath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cfg              (cfg),
    .ctl              (ctl),
    .setpoint         (sample.setpoint),
    .measured         (sample.measured),
    .out_valid        (command.valid),
    .out_ready        (command.ready),
    .out_busy         (out_busy),
    .control_output   (command.control_output),
    .output_saturated (command.output_saturated)
  );

endmodule
`default_nettype wire

// File: design/pfd_regs.sv
// APB configuration register file.
`default_nettype none
module pfd_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [pfd_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output pfd_pkg::cfg_t               cfg
);
  import pfd_pkg::*;

  logic                 wr_en;
  logic [REG_IDX_W-1:0] idx;

  assign wr_en = psel && penable && pwrite;
  assign idx   = paddr[PADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gain_p         <= RST_GAIN;
      cfg.gain_i         <= RST_GAIN;
      cfg.gain_d         <= RST_GAIN;
      cfg.step_time      <= RST_STEP_TIME;
      cfg.step_rate      <= RST_STEP_RATE;
      cfg.filter_alpha   <= RST_ALPHA;
      cfg.integral_limit <= RST_LIMIT;
      cfg.out_clamp      <= RST_LIMIT;
    end else if (wr_en) begin
      unique case (idx)
        REG_GAIN_P:         cfg.gain_p         <= pwdata[COEF_W-1:0];
        REG_GAIN_I:         cfg.gain_i         <= pwdata[COEF_W-1:0];
        REG_GAIN_D:         cfg.gain_d         <= pwdata[COEF_W-1:0];
        REG_STEP_TIME:      cfg.step_time      <= pwdata[COEF_W-1:0];
        REG_STEP_RATE:      cfg.step_rate      <= pwdata[COEF_W-1:0];
        REG_FILTER_ALPHA:   cfg.filter_alpha   <= pwdata[ALPHA_W-1:0];
        REG_INTEGRAL_LIMIT: cfg.integral_limit <= pwdata[COEF_W-1:0];
        REG_OUT_CLAMP:      cfg.out_clamp      <= pwdata[COEF_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_GAIN_P:         prdata = 32'(cfg.gain_p);
      REG_GAIN_I:         prdata = 32'(cfg.gain_i);
      REG_GAIN_D:         prdata = 32'(cfg.gain_d);
      REG_STEP_TIME:      prdata = 32'(cfg.step_time);
      REG_STEP_RATE:      prdata = 32'(cfg.step_rate);
      REG_FILTER_ALPHA:   prdata = 32'(cfg.filter_alpha);
      REG_INTEGRAL_LIMIT: prdata = 32'(cfg.integral_limit);
      REG_OUT_CLAMP:      prdata = 32'(cfg.out_clamp);
      default:            prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

// File: design/pfd_seq.sv
// Microcode sequencer: step counter, control ROM, hold conditions.
`default_nettype none
module pfd_seq (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          out_busy,
  output pfd_pkg::ctl_t ctl
);
  import pfd_pkg::*;

  logic [PC_W-1:0] pc;
  logic [PC_W-1:0] pc_next;
  ctl_word_t       word;
  logic            hold;

  assign word = rom_word(pc);

  always_comb begin
    case (word.cond)
      C_WAIT_IN:  hold = !in_valid;
      C_WAIT_OUT: hold = out_busy;
      default:    hold = 1'b0;
    endcase
  end

  assign in_ready    = (word.cond == C_WAIT_IN);
  assign ctl.mul_sel = word.mul_sel;
  assign ctl.alu_op  = word.alu_op;
  assign ctl.go      = !hold;

  always_comb begin
    if (hold) begin
      pc_next = pc;
    end else if (word.wrap) begin
      pc_next = '0;
    end else begin
      pc_next = pc + PC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= '0;
    end else begin
      pc <= pc_next;
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (pc == PC_W'(1)))
    else $error("accepted word did not start the program");

  a_busy_not_ready: assert property (@(posedge clk) disable iff (rst)
    (pc != '0) |-> !in_ready)
    else $error("ready raised while a word is in progress");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (word.alu_op == OP_OUT && out_busy) |=> (pc == $past(pc)))
    else $error("output step left while result slot busy");

endmodule
`default_nettype wire

// File: design/pfd_datapath.sv
// Shared-multiplier datapath, PID state and output register.
`default_nettype none
module pfd_datapath #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  pfd_pkg::cfg_t      cfg,
  input  pfd_pkg::ctl_t      ctl,
  input  logic signed [31:0] setpoint,
  input  logic signed [31:0] measured,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_busy,
  output logic signed [31:0] control_output,
  output logic               output_saturated
);
  import pfd_pkg::*;

  localparam int PROD_W = 65;
  localparam int ACC_W  = 43;
  localparam int ISUM_W = 42;
  localparam int SHR_W  = PROD_W - GAIN_FRAC;  // product >> 24
  localparam int RHI    = FRAC_BITS + 31;      // top bit of the 32-bit rate

  // state
  logic signed [31:0] integral_sum;
  logic signed [31:0] last_measurement;
  logic signed [31:0] filtered_rate;

  // working registers
  logic signed [32:0]       err;
  logic signed [32:0]       diff;
  logic signed [32:0]       drate;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;

  logic signed [32:0]       mul_a;
  logic signed [31:0]       mul_b;
  logic signed [PROD_W-1:0] mul_p;
  logic [ALPHA_W-1:0]       alpha_c;

  logic signed [SHR_W-1:0]  prod_sh;
  logic signed [ISUM_W-1:0] int_sum;
  logic signed [ISUM_W-1:0] ilim;
  logic signed [31:0]       rate_sat;
  logic signed [ACC_W-1:0]  olim;
  logic [PROD_W-1-RHI:0]    rate_hi;

  assign alpha_c = cfg.filter_alpha[ALPHA_W-1] ? ALPHA_ONE : cfg.filter_alpha;

  always_comb begin
    case (ctl.mul_sel)
      MUL_E_DT:        begin mul_a = err;               mul_b = $signed({1'b0, cfg.step_time}); end
      MUL_DIFF_RINV:   begin mul_a = diff;              mul_b = $signed({1'b0, cfg.step_rate}); end
      MUL_E_KP:        begin mul_a = err;               mul_b = $signed({1'b0, cfg.gain_p}); end
      MUL_DRATE_ALPHA: begin mul_a = drate;             mul_b = $signed({7'd0, alpha_c}); end
      MUL_INT_KI:      begin mul_a = 33'(integral_sum); mul_b = $signed({1'b0, cfg.gain_i}); end
      MUL_FILT_KD:     begin mul_a = 33'(filtered_rate); mul_b = $signed({1'b0, cfg.gain_d}); end
      default:         begin mul_a = '0;                mul_b = '0; end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // floor shift is a plain bit slice of the two's complement product
  assign prod_sh = $signed(prod[PROD_W-1:GAIN_FRAC]);
  assign int_sum = ISUM_W'(integral_sum) + ISUM_W'(prod_sh);
  assign ilim    = $signed({{(ISUM_W-COEF_W){1'b0}}, cfg.integral_limit});
  assign olim    = $signed({{(ACC_W-COEF_W){1'b0}}, cfg.out_clamp});

  // scaled derivative, saturated to 32 bits
  assign rate_hi = prod[PROD_W-1:RHI];
  always_comb begin
    if ((&rate_hi) || !(|rate_hi)) begin
      rate_sat = $signed(prod[RHI:FRAC_BITS]);
    end else if (prod[PROD_W-1]) begin
      rate_sat = 32'sh8000_0000;
    end else begin
      rate_sat = 32'sh7FFF_FFFF;
    end
  end

  assign out_busy = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (ctl.go && ctl.mul_sel != MUL_NONE) begin
      prod <= mul_p;
    end
    if (ctl.go) begin
      case (ctl.alu_op)
        OP_LOAD: begin
          err  <= 33'(setpoint) - 33'(measured);
          diff <= 33'(measured) - 33'(last_measurement);
        end
        OP_RATE:     drate <= 33'(rate_sat) - 33'(filtered_rate);
        OP_ACC_LOAD: acc <= ACC_W'(prod_sh);
        OP_ACC_ADD:  acc <= acc + ACC_W'(prod_sh);
        OP_ACC_SUB:  acc <= acc - ACC_W'(prod_sh);
        OP_OUT: begin
          if (acc > olim) begin
            control_output   <= olim[31:0];
            output_saturated <= 1'b1;
          end else if (acc < -olim) begin
            control_output   <= (-olim[31:0]);
            output_saturated <= 1'b1;
          end else begin
            control_output   <= acc[31:0];
            output_saturated <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // state and control
  always_ff @(posedge clk) begin
    if (rst) begin
      integral_sum     <= '0;
      last_measurement <= '0;
      filtered_rate    <= '0;
      out_valid        <= 1'b0;
    end else begin
      if (ctl.go) begin
        unique case (ctl.alu_op)
          OP_LOAD: last_measurement <= measured;
          OP_INT: begin
            if (int_sum > ilim) begin
              integral_sum <= ilim[31:0];
            end else if (int_sum < -ilim) begin
              integral_sum <= (-ilim[31:0]);
            end else begin
              integral_sum <= int_sum[31:0];
            end
          end
          // result stays between old value and rate, so 32 bits hold it
          OP_FILT: filtered_rate <= filtered_rate + prod_sh[31:0];
          default: ;
        endcase
      end
      if (ctl.go && ctl.alu_op == OP_OUT) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_sat_at_limit: assert property (@(posedge clk) disable iff (rst)
    (out_valid && output_saturated) |->
      (control_output == olim[31:0] || control_output == -olim[31:0]))
    else $error("saturated word not at the limit");

  a_int_clamped: assert property (@(posedge clk) disable iff (rst)
    (ctl.go && ctl.alu_op == OP_INT) |=>
      (ISUM_W'(integral_sum) <= ilim && ISUM_W'(integral_sum) >= -ilim))
    else $error("integral outside its clamp");

endmodule
`default_nettype wire

// File: tb/pid_filtered_derivative_core_tb.sv
// Self-checking testbench for the filtered-derivative PID core.
module pid_filtered_derivative_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pfd_pkg::*;

  localparam int FRAC_BITS = 16;
  localparam int CYCLE_LIMIT = 400000;   // far beyond the slowest legal run
  localparam int SETTLE_CYCLES = 12;     // 9-step program plus margin
  localparam int RAND_PHASES = 7;
  localparam int WORDS_PER_PHASE = 115;

  localparam logic signed [31:0] S_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] S_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] ONE_Q = 32'sh0001_0000;
  localparam longint RATE_MAX = 64'sd2147483647;
  localparam longint RATE_MIN = -64'sd2147483648;

  typedef struct packed {
    logic signed [31:0] setpoint;
    logic signed [31:0] measured;
  } sample_t;

  typedef struct packed {
    logic signed [31:0] control_output;
    logic               output_saturated;
  } command_t;

  logic clk = 1'b0;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  pfd_sample_if  sample_bus();
  pfd_command_if command_bus();

  pid_filtered_derivative_core #(
    .FRAC_BITS(FRAC_BITS)
  ) uut (
    .clk    (clk),
    .rst    (rst),
    .sample (sample_bus),
    .command(command_bus),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  always #5 clk = ~clk;

  // Register copy and loop state mirrored from the core
  cfg_t               pid_cfg;
  logic signed [31:0] integral_acc;
  logic signed [31:0] prev_meas;
  logic signed [31:0] filt_rate;

  sample_t  samples_to_send[$];
  command_t control_words_due[$];

  int words_issued = 0;     // words put on the sample bus (driver side)
  int words_accepted = 0;   // words taken by the core (handshake side)
  int words_checked = 0;
  int fail_count = 0;
  int cycle_count = 0;
  int settings_used = 0;
  int send_idle_pct = 0;    // chance per word of a sender gap burst
  int recv_idle_pct = 0;    // chance per cycle of a receiver stall burst
  int gap_left = 0;
  int stall_left = 0;
  sample_t next_sample;
  command_t want;

  // One PID step on the mirrored state; exact 64-bit products, floor shifts.
  function automatic command_t pid_step(input logic signed [31:0] sp,
                                        input logic signed [31:0] meas);
    longint err;
    longint integ;
    longint rate;
    longint filt;
    longint sum;
    longint alpha;
    longint ilim;
    longint olim;
    logic sat;
    command_t res;
    alpha = longint'(pid_cfg.filter_alpha);
    if (alpha > longint'(ALPHA_ONE)) alpha = longint'(ALPHA_ONE);
    ilim = longint'(pid_cfg.integral_limit);
    olim = longint'(pid_cfg.out_clamp);
    err = longint'(sp) - longint'(meas);

    integ = longint'(integral_acc) + ((err * longint'(pid_cfg.step_time)) >>> GAIN_FRAC);
    if (integ > ilim) integ = ilim;
    else if (integ < -ilim) integ = -ilim;

    // derivative on measurement, saturated to 32 bits before the filter
    rate = ((longint'(meas) - longint'(prev_meas)) * longint'(pid_cfg.step_rate)) >>> FRAC_BITS;
    if (rate > RATE_MAX) rate = RATE_MAX;
    if (rate < RATE_MIN) rate = RATE_MIN;
    filt = longint'(filt_rate) + (((rate - longint'(filt_rate)) * alpha) >>> GAIN_FRAC);

    sum = ((longint'(pid_cfg.gain_p) * err) >>> GAIN_FRAC)
        + ((longint'(pid_cfg.gain_i) * integ) >>> GAIN_FRAC)
        - ((longint'(pid_cfg.gain_d) * filt) >>> GAIN_FRAC);
    sat = 1'b0;
    if (sum > olim) begin
      sum = olim;
      sat = 1'b1;
    end else if (sum < -olim) begin
      sum = -olim;
      sat = 1'b1;
    end

    integral_acc = integ[31:0];
    filt_rate = filt[31:0];
    prev_meas = meas;
    res.control_output = sum[31:0];
    res.output_saturated = sat;
    return res;
  endfunction

  // Mostly plausible coefficients, with zero, full scale and raw noise mixed in
  function automatic logic [30:0] pick_coef(input int unsigned typical);
    logic [30:0] v;
    case ($urandom_range(0, 9))
      0: v = '0;
      1: v = 31'h7FFF_FFFF;
      2: v = 31'($urandom);
      default: v = 31'($urandom_range(0, typical));
    endcase
    return v;
  endfunction

  function automatic cfg_t rand_cfg();
    cfg_t c;
    c.gain_p = pick_coef(32'd67108864);        // up to 4.0
    c.gain_i = pick_coef(32'd67108864);
    c.gain_d = pick_coef(32'd67108864);
    c.step_time = pick_coef(32'd4194304);      // up to 0.25 s
    c.step_rate = pick_coef(32'd67108864);     // up to 1024 per second
    c.integral_limit = pick_coef(32'd13107200);
    c.out_clamp = pick_coef(32'd13107200);
    case ($urandom_range(0, 5))
      0: c.filter_alpha = '0;
      1: c.filter_alpha = ALPHA_ONE;
      2: c.filter_alpha = 25'h1FF_FFFF;        // above one, core must clip
      3: c.filter_alpha = 25'($urandom);
      default: c.filter_alpha = 25'($urandom_range(0, 16777216));
    endcase
    return c;
  endfunction

  function automatic void push_sample(input logic signed [31:0] sp,
                                      input logic signed [31:0] meas);
    sample_t s;
    s.setpoint = sp;
    s.measured = meas;
    samples_to_send.push_back(s);
  endfunction

  // APB access: setup cycle, access cycle; read data sampled at the access edge
  task automatic apb_access(input logic [REG_IDX_W-1:0] idx, input logic wr,
                            input logic [31:0] wdata, output logic [31:0] rdata);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {idx, 2'b00};
    pwdata <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    rdata = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Write every register (junk in the unused high bits), then read each back
  task automatic load_config(input cfg_t c);
    logic [REG_IDX_W-1:0] idx;
    logic [31:0] field;
    logic [31:0] junk;
    logic [31:0] rd;
    for (int i = 0; i < 8; i++) begin
      idx = i[REG_IDX_W-1:0];
      junk = $urandom;
      case (idx)
        REG_GAIN_P:         field = {1'b0, c.gain_p};
        REG_GAIN_I:         field = {1'b0, c.gain_i};
        REG_GAIN_D:         field = {1'b0, c.gain_d};
        REG_STEP_TIME:      field = {1'b0, c.step_time};
        REG_STEP_RATE:      field = {1'b0, c.step_rate};
        REG_FILTER_ALPHA:   field = {7'b0, c.filter_alpha};
        REG_INTEGRAL_LIMIT: field = {1'b0, c.integral_limit};
        default:            field = {1'b0, c.out_clamp};
      endcase
      if (idx == REG_FILTER_ALPHA) apb_access(idx, 1'b1, {junk[31:25], field[24:0]}, rd);
      else apb_access(idx, 1'b1, {junk[31], field[30:0]}, rd);
      apb_access(idx, 1'b0, 32'h0, rd);
      if (rd !== field) begin
        $error("register %0d readback: expected %0h, got %0h", idx, field, rd);
        fail_count++;
      end
    end
    pid_cfg = c;
    settings_used++;
  endtask

  // Block until every queued word went in and every result came back,
  // then let the program counter run out.
  task automatic wait_drained();
    while (samples_to_send.size() != 0 || control_words_due.size() != 0 ||
           words_issued != words_accepted)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Sample driver: hold the word until taken, then maybe a gap burst
  always @(negedge clk) begin
    if (rst) begin
      sample_bus.valid <= 1'b0;
    end else if (words_issued != words_accepted) begin
      // word on the bus still waiting for ready
    end else if (gap_left > 0) begin
      sample_bus.valid <= 1'b0;
      gap_left <= gap_left - 1;
    end else if (samples_to_send.size() == 0) begin
      sample_bus.valid <= 1'b0;
    end else if (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
      sample_bus.valid <= 1'b0;
      gap_left <= $urandom_range(0, 6);   // start an idle burst
    end else begin
      next_sample = samples_to_send.pop_front();
      sample_bus.setpoint <= next_sample.setpoint;
      sample_bus.measured <= next_sample.measured;
      sample_bus.valid <= 1'b1;
      words_issued <= words_issued + 1;
    end
  end

  // Command receiver: random stall bursts
  always @(negedge clk) begin
    if (rst) begin
      command_bus.ready <= 1'b0;
    end else if (stall_left > 0) begin
      command_bus.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (recv_idle_pct > 0 && $urandom_range(0, 99) < recv_idle_pct) begin
      command_bus.ready <= 1'b0;
      stall_left <= $urandom_range(0, 6);
    end else begin
      command_bus.ready <= 1'b1;
    end
  end

  // Handshake monitor: check results against the oldest prediction, and
  // predict a new control word for every accepted sample.
  always @(posedge clk) begin
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words outstanding",
               cycle_count, control_words_due.size());
      $display("[pid_filtered_derivative_core] ERROR");
      $finish;
    end else begin
      cycle_count <= cycle_count + 1;
      if (!rst) begin
        if (command_bus.valid && command_bus.ready) begin
          if (control_words_due.size() == 0) begin
            $error("command word %0h with nothing outstanding", command_bus.control_output);
            fail_count++;
          end else begin
            want = control_words_due.pop_front();
            if (command_bus.control_output !== want.control_output) begin
              $error("control_output: expected %0d, got %0d",
                     want.control_output, command_bus.control_output);
              fail_count++;
            end
            if (command_bus.output_saturated !== want.output_saturated) begin
              $error("output_saturated: expected %0b, got %0b",
                     want.output_saturated, command_bus.output_saturated);
              fail_count++;
            end
            words_checked++;
          end
        end
        if (sample_bus.valid && sample_bus.ready) begin
          control_words_due.push_back(pid_step(sample_bus.setpoint, sample_bus.measured));
          words_accepted <= words_accepted + 1;
        end
      end
    end
  end

  initial begin
    cfg_t c;
    int track_sp;
    int track_meas;

    // every input known from time zero
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    sample_bus.valid = 1'b0;
    sample_bus.setpoint = '0;
    sample_bus.measured = '0;
    command_bus.ready = 1'b0;
    pid_cfg = '{gain_p: RST_GAIN, gain_i: RST_GAIN, gain_d: RST_GAIN,
                step_time: RST_STEP_TIME, step_rate: RST_STEP_RATE,
                filter_alpha: RST_ALPHA, integral_limit: RST_LIMIT,
                out_clamp: RST_LIMIT};
    integral_acc = '0;
    prev_meas = '0;
    filt_rate = '0;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Reset values: zero gains, so only zero words should come out
    send_idle_pct = 20;
    recv_idle_pct = 20;
    push_sample(S_MAX, S_MIN);
    push_sample(ONE_Q, 32'sd0);
    push_sample(-ONE_Q, ONE_Q);
    push_sample(32'sd0, 32'sd0);
    wait_drained();

    // Moderate loop: Kp 2, Ki 1, Kd 0.5, 1 ms, alpha 0.5, tight integral clamp.
    // Field extremes here also overflow the scaled derivative both ways.
    load_config('{gain_p: 31'd33554432, gain_i: 31'd16777216, gain_d: 31'd8388608,
                  step_time: 31'd16777, step_rate: 31'd65536000,
                  filter_alpha: 25'd8388608, integral_limit: 31'd65536,
                  out_clamp: 31'd3276800});
    push_sample(32'sd0, 32'sd0);
    push_sample(S_MAX, S_MIN);      // largest error, derivative floors at int32 min
    push_sample(S_MIN, S_MAX);      // smallest error, derivative tops out
    push_sample(S_MAX, S_MAX);
    push_sample(S_MIN, S_MIN);
    push_sample(32'sd0, S_MAX);
    push_sample(S_MAX, 32'sd0);
    push_sample(S_MIN, 32'sd0);
    push_sample(32'sd0, S_MIN);
    push_sample(ONE_Q, 32'sd0);     // small steps: integral pushes against its clamp
    push_sample(ONE_Q, 32'sd0);
    push_sample(-32'sd1, -32'sd1);
    wait_drained();

    // Zero limits and zero rate: output forced to 0, flag only for nonzero sums
    load_config('{gain_p: 31'd16777216, gain_i: 31'd16777216, gain_d: 31'd16777216,
                  step_time: 31'd16777, step_rate: 31'd0,
                  filter_alpha: 25'h100_0000, integral_limit: 31'd0,
                  out_clamp: 31'd0});
    push_sample(5 * ONE_Q, 32'sd0);
    push_sample(32'sd0, 32'sd0);    // sum exactly zero: no flag
    push_sample(-5 * ONE_Q, 32'sd0);
    push_sample(32'sd0, 3 * ONE_Q);
    push_sample(ONE_Q, ONE_Q);
    wait_drained();

    // Everything at full scale, alpha above one
    load_config('{gain_p: 31'h7FFF_FFFF, gain_i: 31'h7FFF_FFFF, gain_d: 31'h7FFF_FFFF,
                  step_time: 31'h7FFF_FFFF, step_rate: 31'h7FFF_FFFF,
                  filter_alpha: 25'h1FF_FFFF, integral_limit: 31'h7FFF_FFFF,
                  out_clamp: 31'h7FFF_FFFF});
    push_sample(S_MAX, S_MIN);
    push_sample(S_MIN, S_MAX);
    push_sample(32'sd0, 32'sd0);
    push_sample(S_MAX, S_MAX);
    push_sample(S_MIN, S_MIN);
    push_sample(32'sd1, 32'sd0);
    wait_drained();

    // Random settings; most words follow a plant-like trajectory toward a
    // setpoint that steps now and then, the rest are raw noise.
    track_sp = 0;
    track_meas = 0;
    for (int p = 0; p < RAND_PHASES; p++) begin
      c = rand_cfg();
      load_config(c);
      if (p == RAND_PHASES - 1) begin
        send_idle_pct = 0;          // closing stretch runs back to back
        recv_idle_pct = 0;
      end else begin
        case ($urandom_range(0, 3))
          0: send_idle_pct = 0;
          1: send_idle_pct = 10;
          2: send_idle_pct = 30;
          default: send_idle_pct = 60;
        endcase
        case ($urandom_range(0, 3))
          0: recv_idle_pct = 0;
          1: recv_idle_pct = 10;
          2: recv_idle_pct = 30;
          default: recv_idle_pct = 60;
        endcase
      end
      for (int n = 0; n < WORDS_PER_PHASE; n++) begin
        if (n == WORDS_PER_PHASE / 2) wait_drained();   // sender holds off till empty
        if ($urandom_range(0, 3) == 0) begin
          push_sample($urandom, $urandom);
        end else begin
          if ($urandom_range(0, 15) == 0)
            track_sp = int'($urandom_range(0, 26214400)) - 13107200;
          track_meas = track_meas + ((track_sp - track_meas) >>> 3)
                     + int'($urandom_range(0, 131072)) - 65536;
          push_sample(track_sp, track_meas);
        end
      end
      wait_drained();
    end

    $display("checked %0d control words over %0d register settings in %0d cycles",
             words_checked, settings_used + 1, cycle_count);
    $display("covered field extremes, derivative overflow, zero limits, alpha clip, stalls");
    if (fail_count == 0 && control_words_due.size() == 0) begin
      $display("[pid_filtered_derivative_core] OK");
    end else begin
      $display("[pid_filtered_derivative_core] ERROR");
    end
    $finish;
  end

endmodule
